/* rtl/bcc_pkg.sv */
`timescale 1ns / 1ps

package bcc_pkg;

  // Result kinds carried on the output tuser
  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvSingle = 2'd1,
    EvDouble = 2'd2,
    EvLong   = 2'd3
  } event_kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    RegLongLimit1 = 2'd0,
    RegLongLimit2 = 2'd1,
    RegDblWindow1 = 2'd2,
    RegDblWindow2 = 2'd3
  } cfg_reg_e;

  localparam int unsigned CountW = 16;
  localparam int unsigned LevelW = 2;
  localparam int unsigned BtnW   = 2;

  localparam logic [CountW-1:0] LongLimitReset = 16'd10000;
  localparam logic [CountW-1:0] DblWindowReset = 16'd0;

  localparam logic [LevelW-1:0] LevelReleased = 2'd0;
  localparam logic [LevelW-1:0] LevelCode1    = 2'd1;
  localparam logic [LevelW-1:0] LevelCode2    = 2'd2;
  localparam logic [LevelW-1:0] LevelCode3    = 2'd3;

  // Per-button tracking state
  typedef struct packed {
    logic [LevelW-1:0] prev_level;
    logic [LevelW-1:0] held_code;
    logic              press_seen;
    logic              event_done;
    logic [CountW-1:0] hold_count;
    logic [CountW-1:0] gap_count;
  } btn_state_t;

  // Timing limits from the configuration registers
  typedef struct packed {
    logic [CountW-1:0] long_limit1;
    logic [CountW-1:0] long_limit2;
    logic [CountW-1:0] dbl_window1;
    logic [CountW-1:0] dbl_window2;
  } bcc_cfg_t;

endpackage

/* rtl/button_click_classifier.sv */
`timescale 1ns / 1ps

// Button click classifier. Each input word is one tick sample of one button
// (index and level, 0 released, 1 or 2 a press code, 3 taken as 2); each
// sample yields exactly one output word with the button index, an event kind
// on tuser (none, single, double, long press) and the held press code. A
// level change restarts the hold count, a steady level is debounced for
// DEBOUNCE_TICKS samples, then long press fires when the hold count reaches
// the code's long limit, double click on a re-press inside the code's double
// window and single click once the release gap reaches that window. One
// sample is accepted every cycle unless the output stalls; each passes the
// input register, then the result register. Samples to the same button back
// to back see each other's state since the per-button flops are updated in
// the cycle the sample moves into the result register. Indexes at or above
// NUM_BUTTONS change nothing and report no event.
module button_click_classifier import bcc_pkg::*; #(
  parameter int unsigned NUM_BUTTONS    = 4,
  parameter int unsigned DEBOUNCE_TICKS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] button_index, [3:2] sampled_level
  // Event stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] button_out, [3:2] key_code
  output logic [1:0]  m_axis_tuser    // [1:0] event_kind
);

  localparam int unsigned IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  bcc_cfg_t          cfg_q;
  btn_state_t        state_q [NUM_BUTTONS];

  logic              in_valid_q;
  logic [BtnW-1:0]   in_btn_q;
  logic [LevelW-1:0] in_lvl_q;

  logic              out_valid_q;
  logic [BtnW-1:0]   out_btn_q;
  event_kind_e       out_kind_q;
  logic [LevelW-1:0] out_code_q;

  logic              advance;
  logic              in_range;
  logic [IdxW-1:0]   idx;
  btn_state_t        cur_state;
  btn_state_t        nxt_state;
  event_kind_e       step_kind;
  logic [LevelW-1:0] step_code;

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_limit1 <= LongLimitReset;
      cfg_q.long_limit2 <= LongLimitReset;
      cfg_q.dbl_window1 <= DblWindowReset;
      cfg_q.dbl_window2 <= DblWindowReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegLongLimit1: cfg_q.long_limit1 <= cfg_data_i;
        RegLongLimit2: cfg_q.long_limit2 <= cfg_data_i;
        RegDblWindow1: cfg_q.dbl_window1 <= cfg_data_i;
        RegDblWindow2: cfg_q.dbl_window2 <= cfg_data_i;
        default:       cfg_q.long_limit1 <= cfg_q.long_limit1;
      endcase
    end
  end

  // Handshake: move the held sample on when the result register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_btn_q <= s_axis_tdata[1:0];
      in_lvl_q <= s_axis_tdata[3:2];
    end
  end

  // Select the addressed button
  assign in_range  = 32'(in_btn_q) < NUM_BUTTONS;
  assign idx       = IdxW'(in_btn_q);
  assign cur_state = in_range ? state_q[idx] : '0;

  bcc_step #(
    .DEBOUNCE_TICKS(DEBOUNCE_TICKS)
  ) u_step (
    .state_i(cur_state),
    .level_i(in_lvl_q),
    .cfg_i  (cfg_q),
    .state_o(nxt_state),
    .kind_o (step_kind),
    .code_o (step_code)
  );

  // Write back the button state as the sample completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        state_q[i] <= '0;
      end
    end else if (advance && in_range) begin
      state_q[idx] <= nxt_state;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_btn_q  <= in_btn_q;
      out_kind_q <= in_range ? step_kind : EvNone;
      out_code_q <= in_range ? step_code : LevelReleased;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_code_q, out_btn_q};
  assign m_axis_tuser  = out_kind_q;

endmodule

/* rtl/bcc_step.sv */
`timescale 1ns / 1ps

// Next-state and event logic for one tick sample of one button.
module bcc_step import bcc_pkg::*; #(
  parameter int unsigned DEBOUNCE_TICKS = 2
) (
  input  btn_state_t        state_i,
  input  logic [LevelW-1:0] level_i,
  input  bcc_cfg_t          cfg_i,
  output btn_state_t        state_o,
  output event_kind_e       kind_o,
  output logic [LevelW-1:0] code_o
);

  localparam logic [CountW-1:0] Debounce = CountW'(DEBOUNCE_TICKS);

  logic [LevelW-1:0] lv;
  logic [CountW-1:0] long_lim;
  logic [CountW-1:0] press_win;
  logic [CountW-1:0] release_win;
  logic [CountW-1:0] hold_inc;

  // Treat code 3 as code 2
  assign lv = (level_i == LevelCode3) ? LevelCode2 : level_i;

  // Limits for the level being held and for the code captured at press
  assign long_lim  = (lv == LevelCode1) ? cfg_i.long_limit1 : cfg_i.long_limit2;
  assign press_win = (lv == LevelCode1) ? cfg_i.dbl_window1 : cfg_i.dbl_window2;
  always_comb begin
    if (state_i.held_code == LevelReleased) begin
      release_win = '0;
    end else if (state_i.held_code == LevelCode1) begin
      release_win = cfg_i.dbl_window1;
    end else begin
      release_win = cfg_i.dbl_window2;
    end
  end

  // Hold count grows only while below the long limit, so it cannot wrap
  assign hold_inc = (state_i.hold_count < long_lim) ? state_i.hold_count + 1'b1
                                                    : state_i.hold_count;

  // Classify the sample
  always_comb begin
    state_o = state_i;
    kind_o  = EvNone;
    code_o  = LevelReleased;
    priority if (state_i.prev_level != lv) begin
      state_o.prev_level = lv;
      state_o.hold_count = '0;
    end else if (state_i.hold_count < Debounce) begin
      state_o.hold_count = state_i.hold_count + 1'b1;
    end else if (lv != LevelReleased) begin
      state_o.held_code  = lv;
      state_o.hold_count = hold_inc;
      if (hold_inc >= long_lim) begin
        if (!state_i.event_done) begin
          state_o.press_seen = 1'b0;
          state_o.event_done = 1'b1;
          kind_o             = EvLong;
          code_o             = lv;
        end
      end else if (state_i.press_seen) begin
        if (state_i.gap_count != '0 && state_i.gap_count < press_win &&
            !state_i.event_done) begin
          state_o.event_done = 1'b1;
          kind_o             = EvDouble;
          code_o             = lv;
        end
      end else begin
        state_o.press_seen = 1'b1;
        state_o.gap_count  = '0;
      end
    end else begin
      state_o.hold_count = '0;
      if (state_i.gap_count < release_win) begin
        state_o.gap_count = state_i.gap_count + 1'b1;
      end else if (state_i.press_seen && !state_i.event_done) begin
        state_o.press_seen = 1'b0;
        state_o.event_done = 1'b1;
        kind_o             = EvSingle;
        code_o             = state_i.held_code;
      end else begin
        state_o.press_seen = 1'b0;
        state_o.event_done = 1'b0;
      end
    end
  end

endmodule

/* dv/button_click_classifier_tb.sv */
`timescale 1ns / 1ps

module button_click_classifier_tb;
  import bcc_pkg::*;

  localparam int NumButtons    = 4;
  localparam int DebounceTicks = 2;
  localparam int IdlePercent   = 13;
  localparam int NoisePercent  = 12;
  localparam int CycleLimit    = 200000;
  localparam int DrainCycles   = 8;
  localparam int DrainLimit    = 1000;
  localparam int PhaseItems    = 75;
  localparam int NumPhases     = 6;
  localparam int MaxReports    = 100;

  typedef struct packed {
    logic [BtnW-1:0]   button;
    event_kind_e       kind;
    logic [LevelW-1:0] code;
  } click_event_t;

  // Per-button click classification, mirrored tick by tick
  class click_tracker;
    bit [CountW-1:0] long_limit1;
    bit [CountW-1:0] long_limit2;
    bit [CountW-1:0] dbl_window1;
    bit [CountW-1:0] dbl_window2;
    bit [LevelW-1:0] prev_level [NumButtons];
    bit [LevelW-1:0] held_code  [NumButtons];
    bit              press_seen [NumButtons];
    bit              event_done [NumButtons];
    bit [CountW-1:0] hold_count [NumButtons];
    bit [CountW-1:0] gap_count  [NumButtons];
    click_event_t    pending_events [$];

    function new();
      long_limit1 = LongLimitReset;
      long_limit2 = LongLimitReset;
      dbl_window1 = DblWindowReset;
      dbl_window2 = DblWindowReset;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [CountW-1:0] value);
      case (idx)
        RegLongLimit1: long_limit1 = value;
        RegLongLimit2: long_limit2 = value;
        RegDblWindow1: dbl_window1 = value;
        RegDblWindow2: dbl_window2 = value;
        default: ;
      endcase
    endfunction

    function bit [CountW-1:0] long_limit_of(bit [LevelW-1:0] code);
      return (code == LevelCode1) ? long_limit1 : long_limit2;
    endfunction

    // A button never pressed has no double window
    function bit [CountW-1:0] window_of(bit [LevelW-1:0] code);
      if (code == LevelReleased) return '0;
      return (code == LevelCode1) ? dbl_window1 : dbl_window2;
    endfunction

    // Advance one button by one tick and queue the event it yields
    function void note_sample(bit [BtnW-1:0] b, bit [LevelW-1:0] raw);
      bit [LevelW-1:0] lv;
      bit [CountW-1:0] lim;
      bit [CountW-1:0] win;
      click_event_t    ev;
      lv = (raw == LevelCode3) ? LevelCode2 : raw;
      ev.button = b;
      ev.kind   = EvNone;
      ev.code   = LevelReleased;
      if (b < NumButtons) begin
        if (prev_level[b] != lv) begin
          prev_level[b] = lv;
          hold_count[b] = '0;
        end else if (hold_count[b] < DebounceTicks) begin
          hold_count[b]++;
        end else if (lv != LevelReleased) begin
          held_code[b] = lv;
          lim = long_limit_of(lv);
          if (hold_count[b] < lim) hold_count[b]++;
          if (hold_count[b] >= lim) begin
            if (!event_done[b]) begin
              press_seen[b] = 1'b0;
              event_done[b] = 1'b1;
              ev.kind = EvLong;
              ev.code = lv;
            end
          end else if (press_seen[b]) begin
            win = window_of(lv);
            if (gap_count[b] != 0 && gap_count[b] < win && !event_done[b]) begin
              event_done[b] = 1'b1;
              ev.kind = EvDouble;
              ev.code = lv;
            end
          end else begin
            press_seen[b] = 1'b1;
            gap_count[b]  = '0;
          end
        end else begin
          win = window_of(held_code[b]);
          hold_count[b] = '0;
          if (gap_count[b] < win) begin
            gap_count[b]++;
          end else if (press_seen[b] && !event_done[b]) begin
            press_seen[b] = 1'b0;
            event_done[b] = 1'b1;
            ev.kind = EvSingle;
            ev.code = held_code[b];
          end else begin
            press_seen[b] = 1'b0;
            event_done[b] = 1'b0;
          end
        end
      end
      pending_events.push_back(ev);
    endfunction

    // Compare one observed event with the oldest pending one; empty string on match
    function string check_event(click_event_t got);
      click_event_t want;
      string        msg;
      if (pending_events.size() == 0)
        return $sformatf("event with nothing pending: button %0d kind %0d code %0d",
                         got.button, got.kind, got.code);
      want = pending_events.pop_front();
      msg  = "";
      if (got.button !== want.button)
        msg = {msg, $sformatf(" button %0d/%0d", got.button, want.button)};
      if (got.kind !== want.kind)
        msg = {msg, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.code !== want.code)
        msg = {msg, $sformatf(" code %0d/%0d", got.code, want.code)};
      if (msg != "")
        msg = {$sformatf("button %0d event wrong (got/want):", want.button), msg};
      return msg;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [1:0] button_index, [3:2] sampled_level
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [1:0] button_out, [3:2] key_code
  logic [1:0]  m_axis_tuser;   // [1:0] event_kind

  click_tracker    tracker;
  int              mismatch_count = 0;
  int              cycle_count    = 0;
  logic            no_idle        = 1'b0;
  logic [BtnW-1:0] cur_button     = '0;
  logic [1:0]      run_level [NumButtons];
  int              run_left  [NumButtons];

  button_click_classifier #(
    .NUM_BUTTONS    (NumButtons),
    .DEBOUNCE_TICKS (DebounceTicks)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Stall the event side at random
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IdlePercent);
  end

  // Watch every handshake: note writes and samples, check events
  always @(posedge clk_i) begin
    click_event_t got;
    string        msg;
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** button_click_classifier: FAILED **");
      $finish;
    end else if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        tracker.write_reg(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_sample(s_axis_tdata[1:0], s_axis_tdata[3:2]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.button = m_axis_tdata[1:0];
        got.kind   = event_kind_e'(m_axis_tuser);
        got.code   = m_axis_tdata[3:2];
        msg = tracker.check_event(got);
        if (msg != "") report(msg);
      end
    end
  end

  // Offer one sample word, idling first at random, and hold until accepted
  task automatic send_sample(logic [BtnW-1:0] b, logic [LevelW-1:0] lvl);
    while (!no_idle && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, lvl, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic hold_level(logic [BtnW-1:0] b, logic [LevelW-1:0] lvl, int ticks);
    repeat (ticks) send_sample(b, lvl);
  endtask

  // Write all four timing registers back to back
  task automatic write_config(logic [15:0] l1, logic [15:0] l2,
                              logic [15:0] w1, logic [15:0] w2);
    logic [15:0] values [4];
    values = '{l1, l2, w1, w2};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i  <= values[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid and wait for every pending event to come out
  task automatic drain();
    int waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    // Let the last accepted word reach the tracker first
    @(posedge clk_i);
    while (tracker.pending_events.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.pending_events.size() != 0)
      report($sformatf("%0d events never arrived", tracker.pending_events.size()));
  endtask

  // Mostly press/release runs per button, interleaved, with some noise words
  task automatic random_phase(int n_items);
    logic [BtnW-1:0] b;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < NoisePercent) begin
        send_sample(2'($urandom), 2'($urandom));
      end else begin
        if ($urandom_range(0, 99) < 30) cur_button = 2'($urandom);
        b = cur_button;
        if (run_left[b] == 0) begin
          if (run_level[b] != LevelReleased && $urandom_range(0, 99) < 75)
            run_level[b] = LevelReleased;
          else
            run_level[b] = 2'($urandom_range(1, 3));
          run_left[b] = $urandom_range(1, 14);
        end
        run_left[b]--;
        send_sample(b, run_level[b]);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegLongLimit1;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    for (int i = 0; i < NumButtons; i++) begin
      run_level[i] = LevelReleased;
      run_left[i]  = 0;
    end
    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits: code 3 taken as code 2, release before any press
    hold_level(2'd0, LevelCode3, 2);
    hold_level(2'd1, LevelReleased, 3);
    drain();

    // Short limits: long press, single click, double click
    write_config(16'd4, 16'd6, 16'd0, 16'd4);
    hold_level(2'd2, LevelCode1, 5);
    hold_level(2'd3, LevelCode1, 4);
    hold_level(2'd3, LevelReleased, 4);
    hold_level(2'd1, LevelCode2, 4);
    hold_level(2'd1, LevelReleased, 4);
    hold_level(2'd1, LevelCode2, 4);
    drain();

    // Random phases: all-zero limits, all-ones limits, then random, mostly small ones
    for (int phase = 0; phase < NumPhases; phase++) begin
      no_idle <= (phase == 2);
      case (phase)
        0: write_config('0, '0, '0, '0);
        1: write_config('1, '1, '1, '1);
        default: write_config(
            ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16)),
            ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16)),
            16'($urandom_range(0, 8)),
            16'($urandom_range(0, 8)));
      endcase
      random_phase(PhaseItems);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("** button_click_classifier: PASSED **");
    end else begin
      $display("** button_click_classifier: FAILED **");
    end
    $finish;
  end

endmodule
